// ===== design/cal_pkg.sv =====
package cal_pkg;

    // command codes (input tuser)
    localparam logic [2:0] CMD_APPEND  = 3'd0;
    localparam logic [2:0] CMD_READ    = 3'd1;
    localparam logic [2:0] CMD_REMOVE  = 3'd2;
    localparam logic [2:0] CMD_RESTART = 3'd3;
    localparam logic [2:0] CMD_NEXT    = 3'd4;

    // status codes (output tuser)
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_INDEX = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_CHANGED   = 3'd4;
    localparam logic [2:0] ST_END       = 3'd5;

    localparam int DATA_BITS   = 32;
    localparam int INDEX_BITS  = 8;
    localparam int COUNT_BITS  = 9;
    localparam int CHANGE_BITS = 16;

    typedef logic [DATA_BITS-1:0]   data_t;
    typedef logic [CHANGE_BITS-1:0] change_t;

    localparam data_t ERR_DATA = '1;

endpackage

// ===== design/compacting_array_list.sv =====
// Ordered list of signed words held in a single-port-pair RAM (one write, one
// registered read per cycle), with one fail-fast iterator. Commands come in on
// s_axis with the command code in tuser; one result word leaves on m_axis per
// command, status code in tuser, -1 in the data field on any error. Append,
// restart, ignored codes and every error case load the result register from
// idle; read and iterator next go through S_READ for the registered RAM read.
// Remove at index i runs S_REMOVE, then S_SHIFT once per held entry above
// i, moving one entry down per cycle (read entry k, write entry k-2 <- k-1).
// One command is in work at a time; a new word is taken as soon as the block
// is back in idle and the result register is empty or being drained.
// Entries hold WORD_BITS bits: the input value is sign-extended or truncated
// to that width, and read data is zero-extended or truncated to 32 bits.
// No clearing pass: only entries below the fill level are ever read.
module compacting_array_list
    import cal_pkg::*;
#(
    parameter int CAPACITY  = 256,
    parameter int WORD_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // index[7:0], value[39:8]
    input  logic [2:0]  s_axis_tuser,  // command[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // data[31:0], count[40:32], is_empty[41], zero[47:42]
    output logic [2:0]  m_axis_tuser   // status[2:0]
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > INDEX_BITS) ? CW : INDEX_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_REMOVE,
        S_SHIFT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   fill_reg, fill_next;
    change_t         change_reg, change_next;
    logic [CW-1:0]   cursor_reg, cursor_next;
    change_t         snap_reg, snap_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    data_t           removed_reg, removed_next;
    logic            m_valid_reg, m_valid_next;
    data_t           out_data_reg;
    logic [2:0]      out_status_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic            out_empty_reg;

    logic                 accept;
    logic [2:0]           cmd;
    logic [INDEX_BITS-1:0] idx;
    data_t                val;
    logic [CMPW-1:0]      idx_ext;
    logic [CMPW-1:0]      fill_ext;
    logic                 idx_ok;
    logic [63:0]          val_wide;
    logic [63:0]          rd_wide;
    data_t                rd32;
    logic [CW-1:0]        ptr_inc;
    logic [CW-1:0]        ptr_dec;
    logic                 more;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                 out_load;
    data_t                ld_data;
    logic [2:0]           ld_status;

    cal_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign cmd      = s_axis_tuser;
    assign idx      = s_axis_tdata[7:0];
    assign val      = s_axis_tdata[39:8];
    assign idx_ext  = CMPW'(idx);
    assign fill_ext = CMPW'(fill_reg);
    assign idx_ok   = idx_ext < fill_ext;

    assign val_wide = {{32{val[31]}}, val};
    assign rd_wide  = 64'(ram_rdata);
    assign rd32     = rd_wide[31:0];

    // ptr_reg < fill_reg <= CAPACITY while shifting, so no wrap here
    assign ptr_inc = ptr_reg + 1'b1;
    assign ptr_dec = ptr_reg - 1'b1;
    assign more    = ptr_inc < fill_reg;

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        change_next  = change_reg;
        cursor_next  = cursor_reg;
        snap_next    = snap_reg;
        ptr_next     = ptr_reg;
        removed_next = removed_reg;
        ram_we       = 1'b0;
        ram_waddr    = fill_reg[AW-1:0];
        ram_wdata    = val_wide[WORD_BITS-1:0];
        ram_raddr    = idx_ext[AW-1:0];
        out_load     = 1'b0;
        ld_data      = '0;
        ld_status    = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_APPEND:
                        begin
                            out_load = 1'b1;
                            if (fill_reg == CW'(CAPACITY))
                            begin
                                ld_status = ST_FULL;
                                ld_data   = ERR_DATA;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                fill_next   = fill_reg + 1'b1;
                                change_next = change_reg + 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            if (idx_ok)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                out_load  = 1'b1;
                                ld_status = ST_BAD_INDEX;
                                ld_data   = ERR_DATA;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (fill_reg == '0)
                            begin
                                out_load  = 1'b1;
                                ld_status = ST_EMPTY;
                                ld_data   = ERR_DATA;
                            end
                            else if (!idx_ok)
                            begin
                                out_load  = 1'b1;
                                ld_status = ST_BAD_INDEX;
                                ld_data   = ERR_DATA;
                            end
                            else
                            begin
                                ptr_next   = idx_ext[CW-1:0];
                                state_next = S_REMOVE;
                            end
                        end
                        CMD_RESTART:
                        begin
                            out_load    = 1'b1;
                            cursor_next = '0;
                            snap_next   = change_reg;
                        end
                        CMD_NEXT:
                        begin
                            if (snap_reg != change_reg)
                            begin
                                out_load  = 1'b1;
                                ld_status = ST_CHANGED;
                                ld_data   = ERR_DATA;
                            end
                            else if (cursor_reg >= fill_reg)
                            begin
                                out_load  = 1'b1;
                                ld_status = ST_END;
                                ld_data   = ERR_DATA;
                            end
                            else
                            begin
                                ram_raddr   = cursor_reg[AW-1:0];
                                cursor_next = cursor_reg + 1'b1;
                                state_next  = S_READ;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_load   = 1'b1;
                ld_data    = rd32;
                state_next = S_IDLE;
            end
            S_REMOVE, S_SHIFT:
            begin
                // S_REMOVE: read data is the removed entry.
                // S_SHIFT: read data is entry ptr, moved down to ptr-1.
                if (state_reg == S_REMOVE)
                begin
                    removed_next = rd32;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ptr_dec[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if (more)
                begin
                    ram_raddr  = ptr_inc[AW-1:0];
                    ptr_next   = ptr_inc;
                    state_next = S_SHIFT;
                end
                else
                begin
                    out_load    = 1'b1;
                    ld_data     = (state_reg == S_REMOVE) ? rd32 : removed_reg;
                    fill_next   = fill_reg - 1'b1;
                    change_next = change_reg + 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            change_reg  <= '0;
            cursor_reg  <= '0;
            snap_reg    <= '0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            change_reg  <= change_next;
            cursor_reg  <= cursor_next;
            snap_reg    <= snap_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg <= removed_next;
        if (out_load)
        begin
            out_data_reg   <= ld_data;
            out_status_reg <= ld_status;
            out_count_reg  <= COUNT_BITS'(fill_next);
            out_empty_reg  <= (fill_next == '0);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'b0, out_empty_reg, out_count_reg, out_data_reg};
    assign m_axis_tuser  = out_status_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(CAPACITY))
        else $error("fill level above capacity");

    a_remove_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd == CMD_REMOVE && fill_reg != '0 && idx_ok |=> state_reg == S_REMOVE)
        else $error("valid remove did not start the shift sequence");

    a_shift_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> (ptr_reg < fill_reg) && (ptr_reg != '0))
        else $error("shift pointer out of range");

    a_change_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) == (change_reg != $past(change_reg)))
        else $error("change count out of step with fill level");

    a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !m_valid_reg)
        else $error("result pending while a command is in work");

endmodule

// ===== design/cal_ram.sv =====
module cal_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
